// ===== rtl/core/fqs_pkg.sv =====
// Shared types, constants and helpers for the searchable FIFO queue.
`timescale 1ns / 1ps

package fqs_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_FLUSH  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_DATA,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic    cap;
    logic    res_init;
    status_t status;
    logic    push;
    logic    pop_rd;
    logic    flush;
    logic    scan_start;
    logic    scan_step;
    logic    set_value;
    logic    set_hit;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    op_t  func;
    logic full;
    logic empty;
    logic match;
    logic scan_last;
    logic out_free;
  } sts_t;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] pos);
    logic [IDX_W-1:0] inc;
    inc = pos + IDX_W'(1);
    return (pos == IDX_W'(DEPTH - 1)) ? '0 : inc;
  endfunction

endpackage

// ===== rtl/core/fifo_queue_with_search.sv =====
// Top level of the searchable FIFO queue: controller plus datapath.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_func, in_value
//   out      output     out_valid / out_ready  out_value, out_hit, out_occupancy,
//                                              out_is_empty, out_status
//
// A new item is accepted only once the previous result has gone to the output register;
// a search compares n (at most DEPTH) entries in turn, up to a hit or the end,
// one at a time through the single read port of the entry store and one comparator.
// Reset (rst_n low, synchronous) empties the queue; no clearing pass is needed.
// A finished result sits in the output register while the next item is taken;
// a further result waits in the result registers until out_ready frees that register.
`timescale 1ns / 1ps

module fifo_queue_with_search (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_func,
  input  logic signed [fqs_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [fqs_pkg::DATA_W-1:0] out_value,
  output logic                              out_hit,
  output logic [fqs_pkg::OCC_W-1:0]         out_occupancy,
  output logic                              out_is_empty,
  output logic [1:0]                        out_status
);

  fqs_pkg::cmd_t cmd;
  fqs_pkg::sts_t sts;

  fqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fqs_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_func       (in_func),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .out_hit       (out_hit),
    .out_occupancy (out_occupancy),
    .out_is_empty  (out_is_empty),
    .out_status    (out_status)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous item still in progress");

  a_hit_needs_entries: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> (out_status == fqs_pkg::ST_OK) && !out_is_empty)
    else $error("search hit reported on empty queue or with error status");

  a_pop_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == fqs_pkg::ST_POP_EMPTY) |-> out_is_empty && (out_value == '0))
    else $error("pop on empty returned data or non-empty queue");

  a_push_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == fqs_pkg::ST_PUSH_FULL) |-> !out_is_empty && !out_hit)
    else $error("push on full reported with empty queue or hit");

endmodule

// ===== rtl/core/fqs_ctrl.sv =====
// Control state machine: sequences push, pop, search scan, flush and result hand-off.
`timescale 1ns / 1ps

module fqs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  fqs_pkg::sts_t sts,
  output fqs_pkg::cmd_t cmd
);

  fqs_pkg::state_t state_r;
  fqs_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fqs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.status = fqs_pkg::ST_OK;
    in_ready   = 1'b0;
    unique case (state_r)
      fqs_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = fqs_pkg::S_EXEC;
        end
      end
      fqs_pkg::S_EXEC: begin
        cmd.res_init = 1'b1;
        state_nxt    = fqs_pkg::S_EMIT;
        unique case (sts.func)
          fqs_pkg::OP_PUSH: begin
            if (sts.full) begin
              cmd.status = fqs_pkg::ST_PUSH_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end
          fqs_pkg::OP_POP: begin
            if (sts.empty) begin
              cmd.status = fqs_pkg::ST_POP_EMPTY;
            end else begin
              cmd.pop_rd = 1'b1;
              state_nxt  = fqs_pkg::S_POP_DATA;
            end
          end
          fqs_pkg::OP_SEARCH: begin
            if (!sts.empty) begin
              cmd.scan_start = 1'b1;
              state_nxt      = fqs_pkg::S_SCAN;
            end
          end
          fqs_pkg::OP_FLUSH: begin
            cmd.flush = 1'b1;
          end
          default: ;
        endcase
      end
      fqs_pkg::S_POP_DATA: begin
        cmd.set_value = 1'b1;
        state_nxt     = fqs_pkg::S_EMIT;
      end
      fqs_pkg::S_SCAN: begin
        priority if (sts.match) begin
          cmd.set_hit = 1'b1;
          state_nxt   = fqs_pkg::S_EMIT;
        end else if (sts.scan_last) begin
          state_nxt = fqs_pkg::S_EMIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      fqs_pkg::S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = fqs_pkg::S_IDLE;
        end
      end
      default: state_nxt = fqs_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/fqs_dp.sv =====
// Datapath: entry store, ring pointers, scan unit, result and output registers.
`timescale 1ns / 1ps

module fqs_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fqs_pkg::cmd_t                cmd,
  output fqs_pkg::sts_t                sts,
  input  logic [1:0]                   in_func,
  input  logic signed [fqs_pkg::DATA_W-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [fqs_pkg::DATA_W-1:0] out_value,
  output logic                         out_hit,
  output logic [fqs_pkg::OCC_W-1:0]    out_occupancy,
  output logic                         out_is_empty,
  output logic [1:0]                   out_status
);

  localparam int IW = fqs_pkg::IDX_W;
  localparam int CW = fqs_pkg::CNT_W;
  localparam int DW = fqs_pkg::DATA_W;

  logic [DW-1:0]   mem [fqs_pkg::DEPTH];
  logic [DW-1:0]   rd_data_r;
  logic            rd_en;
  logic [IW-1:0]   rd_addr;

  fqs_pkg::op_t    func_r;
  logic [DW-1:0]   key_r;

  logic [IW-1:0]   head_r, head_nxt;
  logic [IW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [IW-1:0]   scan_ptr_r;
  logic [CW-1:0]   scan_left_r;

  logic [DW-1:0]   res_value_r;
  logic            res_hit_r;
  fqs_pkg::status_t res_status_r;

  logic            out_valid_r, out_valid_nxt;
  logic [DW-1:0]   out_value_r;
  logic            out_hit_r;
  logic [fqs_pkg::OCC_W-1:0] out_occ_r;
  logic            out_empty_r;
  fqs_pkg::status_t out_status_r;

  // single read port: head for pop and scan start, scan pointer while scanning
  assign rd_en   = cmd.pop_rd | cmd.scan_start | cmd.scan_step;
  assign rd_addr = cmd.scan_step ? scan_ptr_r : head_r;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail_r] <= key_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    priority if (cmd.flush) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else if (cmd.push) begin
      tail_nxt  = fqs_pkg::ring_next(tail_r);
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop_rd) begin
      head_nxt  = fqs_pkg::ring_next(head_r);
      count_nxt = count_r - CW'(1);
    end else begin
    end
  end

  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      func_r <= fqs_pkg::op_t'(in_func);
      key_r  <= in_value;
    end
    if (cmd.scan_start) begin
      scan_ptr_r  <= fqs_pkg::ring_next(head_r);
      scan_left_r <= count_r - CW'(1);
    end else if (cmd.scan_step) begin
      scan_ptr_r  <= fqs_pkg::ring_next(scan_ptr_r);
      scan_left_r <= scan_left_r - CW'(1);
    end
    if (cmd.res_init) begin
      res_value_r  <= '0;
      res_hit_r    <= 1'b0;
      res_status_r <= cmd.status;
    end
    if (cmd.set_value) begin
      res_value_r <= rd_data_r;
    end
    if (cmd.set_hit) begin
      res_hit_r <= 1'b1;
    end
    if (cmd.emit) begin
      out_value_r  <= res_value_r;
      out_hit_r    <= res_hit_r;
      out_occ_r    <= fqs_pkg::OCC_W'(count_r);
      out_empty_r  <= (count_r == '0);
      out_status_r <= res_status_r;
    end
  end

  assign sts.func      = func_r;
  assign sts.full      = (count_r == CW'(fqs_pkg::DEPTH));
  assign sts.empty     = (count_r == '0);
  assign sts.match     = (rd_data_r == key_r);
  assign sts.scan_last = (scan_left_r == '0);
  assign sts.out_free  = ~out_valid_r | out_ready;

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_hit       = out_hit_r;
  assign out_occupancy = out_occ_r;
  assign out_is_empty  = out_empty_r;
  assign out_status    = out_status_r;

endmodule
